@@ src/cbmm_pkg.sv @@
// shared types and constants for the console bus memory map
// used by cbmm_ram, cbmm_decode and console_bus_memory_map_core; no dependencies
package cbmm_pkg;

	// internal ram geometry
	localparam int RAM_AW    = 11;
	localparam int RAM_DEPTH = 1 << RAM_AW;
	localparam int RAM_DW    = 8;
	localparam int PAL_AW    = 5;
	localparam int PAL_DEPTH = 1 << PAL_AW;
	localparam int PAL_DW    = 6;

	// target codes on the result channel
	localparam logic [3:0] TGT_CPU_RAM    = 4'd0;
	localparam logic [3:0] TGT_PPU_REG    = 4'd1;
	localparam logic [3:0] TGT_PAD1       = 4'd2;
	localparam logic [3:0] TGT_PAD2       = 4'd3;
	localparam logic [3:0] TGT_PAD_BOTH   = 4'd4;
	localparam logic [3:0] TGT_MAPPER_CPU = 4'd5;
	localparam logic [3:0] TGT_NAMETABLE  = 4'd6;
	localparam logic [3:0] TGT_PALETTE    = 4'd7;
	localparam logic [3:0] TGT_MAPPER_CHR = 4'd8;
	localparam logic [3:0] TGT_UNMAPPED   = 4'd9;

	// access modes
	localparam logic [1:0] MODE_CPU_RD = 2'd0;
	localparam logic [1:0] MODE_CPU_WR = 2'd1;
	localparam logic [1:0] MODE_PPU_RD = 2'd2;
	localparam logic [1:0] MODE_PPU_WR = 2'd3;

	// nametable mirroring modes
	localparam logic [1:0] MIR_VERTICAL   = 2'd0;
	localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
	localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
	localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

	// which store serves an access
	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_WRAM,
		KIND_NT,
		KIND_PAL,
		KIND_EXT
	} kind_t;

	// decoded access
	typedef struct packed {
		logic                is_write;
		logic [3:0]          target;
		logic [15:0]         eaddr;
		kind_t               kind;
		logic [RAM_AW-1:0]   wram_addr;
		logic [RAM_AW-1:0]   nt_addr;
		logic [PAL_AW-1:0]   pal_idx;
	} dec_t;

endpackage

@@ src/cbmm_ram.sv @@
// single port synchronous ram, 2048 x 8, registered read data
// depends on cbmm_pkg for its geometry
module cbmm_ram import cbmm_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [RAM_AW-1:0] addr,
	input  logic [RAM_DW-1:0] wdata,
	output logic [RAM_DW-1:0] rdata
);

	logic [RAM_DW-1:0] mem [RAM_DEPTH];
	logic [RAM_DW-1:0] rdata_q;

	// one access per cycle, read data valid the cycle after
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/cbmm_decode.sv @@
// address decoder for cpu and ppu bus accesses, including mirroring folds
// depends on cbmm_pkg for codes and the decoded access struct
module cbmm_decode import cbmm_pkg::*; (
	input  logic [1:0]  mode,
	input  logic [15:0] address,
	input  logic [1:0]  mirroring,
	output dec_t        dec
);

	logic [13:0] ppu_addr;
	logic [11:0] nt_off;
	logic [4:0]  pal_raw;

	assign ppu_addr = address[13:0];
	assign nt_off   = ppu_addr[11:0];
	assign pal_raw  = ppu_addr[4:0];

	always_comb begin
		dec.is_write  = mode[0];
		dec.target    = TGT_UNMAPPED;
		dec.eaddr     = address;
		dec.kind      = KIND_NONE;
		dec.wram_addr = address[RAM_AW-1:0];
		dec.nt_addr   = nt_off[RAM_AW-1:0];
		dec.pal_idx   = pal_raw;

		// nametable fold by mirroring mode
		case (mirroring)
			MIR_VERTICAL:   dec.nt_addr = nt_off[10:0];
			MIR_HORIZONTAL: dec.nt_addr = {nt_off[11], nt_off[9:0]};
			MIR_SINGLE_LO:  dec.nt_addr = {1'b0, nt_off[9:0]};
			MIR_SINGLE_HI:  dec.nt_addr = {1'b1, nt_off[9:0]};
			default:        dec.nt_addr = nt_off[10:0];
		endcase

		// backdrop entries of sprite palettes alias the background ones
		if (pal_raw[4] && (pal_raw[1:0] == 2'b00)) begin
			dec.pal_idx = {1'b0, pal_raw[3:0]};
		end

		case (mode)
			MODE_CPU_RD, MODE_CPU_WR: begin
				if (address <= 16'h1FFF) begin
					dec.target = TGT_CPU_RAM;
					dec.kind   = KIND_WRAM;
				end else if (address <= 16'h3FFF) begin
					dec.target = TGT_PPU_REG;
					dec.eaddr  = {13'd0, address[2:0]};
					dec.kind   = KIND_EXT;
				end else if (address == 16'h4016) begin
					dec.target = mode[0] ? TGT_PAD_BOTH : TGT_PAD1;
					dec.kind   = KIND_EXT;
				end else if ((address == 16'h4017) && !mode[0]) begin
					dec.target = TGT_PAD2;
					dec.kind   = KIND_EXT;
				end else if (address >= 16'h4020) begin
					dec.target = TGT_MAPPER_CPU;
					dec.kind   = KIND_EXT;
				end else begin
					dec.target = TGT_UNMAPPED;
					dec.kind   = KIND_NONE;
				end
			end
			MODE_PPU_RD, MODE_PPU_WR: begin
				dec.eaddr = {2'b00, ppu_addr};
				if (ppu_addr <= 14'h1FFF) begin
					dec.target = TGT_MAPPER_CHR;
					dec.kind   = KIND_EXT;
				end else if (ppu_addr <= 14'h3EFF) begin
					dec.target = TGT_NAMETABLE;
					dec.kind   = KIND_NT;
				end else begin
					dec.target = TGT_PALETTE;
					dec.kind   = KIND_PAL;
				end
			end
			default: begin
				dec.target = TGT_UNMAPPED;
				dec.kind   = KIND_NONE;
			end
		endcase
	end

endmodule

@@ src/console_bus_memory_map_core.sv @@
// console bus memory map: decodes cpu and ppu accesses and serves the internal rams
// depends on cbmm_pkg, cbmm_decode and cbmm_ram
//
// Usage:
// - input channel (in_valid/in_ready) carries one bus access per transfer: mode,
//   address, write_data and the external device's read byte (ext_data, ext_valid)
// - result channel (out_valid/out_ready) returns read_data, target, ext_address
//   and ext_write, one result per access, in order
// - cfg_we/cfg_wdata write the nametable mirroring mode; the user must write it
//   only while idle, as the block leaves it unchecked
// - an access is decoded and issued to work ram, nametable ram or palette at its
//   transfer edge; the open-bus latch and output register load when s1 advances
// - one access per cycle while out_ready keeps up, set by the single ram port of
//   each memory, which also orders a write and a following read of the same entry
// - after reset both 2 KiB rams are cleared one entry per cycle, with in_ready low
//   until all 2048 entries are done; palette and latch clear at once
// - when the receiver stalls, one result waits in the output register and one
//   more in the s1 stage; in_ready drops only when both are full
module console_bus_memory_map_core import cbmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  ext_data,
	input  logic        ext_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [3:0]  target,
	output logic [15:0] ext_address,
	output logic        ext_write
);

	logic [1:0]        mirroring_q;
	logic [RAM_AW-1:0] clr_cnt_q;
	logic              clr_done_q;
	logic [7:0]        latch_q;
	logic [PAL_DW-1:0] pal_q [PAL_DEPTH];

	dec_t              dec;
	logic              accept;
	logic              s1_adv;

	logic              wram_en, nt_en, ram_we;
	logic [RAM_AW-1:0] wram_addr, nt_addr;
	logic [RAM_DW-1:0] ram_wdata, wram_rdata, nt_rdata;

	logic              s1_valid_q;
	logic              s1_is_write_s1;
	logic [3:0]        s1_target_s1;
	logic [15:0]       s1_eaddr_s1;
	kind_t             s1_kind_s1;
	logic [7:0]        s1_edata_s1;
	logic              s1_evalid_s1;
	logic [PAL_DW-1:0] s1_pal_s1;

	logic [7:0]        rdata_c;
	logic              latch_we;
	logic              ewrite_c;

	logic              out_valid_q;
	logic [7:0]        read_data_q;
	logic [3:0]        target_q;
	logic [15:0]       ext_address_q;
	logic              ext_write_q;

	// mirroring register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirroring_q <= MIR_VERTICAL;
		end else if (cfg_we) begin
			mirroring_q <= cfg_wdata;
		end
	end

	// clearing pass over both 2 KiB rams after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {RAM_AW{1'b1}}) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	cbmm_decode u_decode (
		.mode      (mode),
		.address   (address),
		.mirroring (mirroring_q),
		.dec       (dec)
	);

	// handshake and stage advance
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = clr_done_q && (!s1_valid_q || s1_adv);
	assign accept   = in_valid && in_ready;

	// ram port muxing, clear pass takes both ports
	assign ram_we    = !clr_done_q || dec.is_write;
	assign ram_wdata = clr_done_q ? write_data : '0;
	assign wram_en   = !clr_done_q || (accept && (dec.kind == KIND_WRAM));
	assign nt_en     = !clr_done_q || (accept && (dec.kind == KIND_NT));
	assign wram_addr = clr_done_q ? dec.wram_addr : clr_cnt_q;
	assign nt_addr   = clr_done_q ? dec.nt_addr : clr_cnt_q;

	cbmm_ram u_work_ram (
		.clk   (clk),
		.en    (wram_en),
		.we    (ram_we),
		.addr  (wram_addr),
		.wdata (ram_wdata),
		.rdata (wram_rdata)
	);

	cbmm_ram u_nametable_ram (
		.clk   (clk),
		.en    (nt_en),
		.we    (ram_we),
		.addr  (nt_addr),
		.wdata (ram_wdata),
		.rdata (nt_rdata)
	);

	// palette entries, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAL_DEPTH; i++) begin
				pal_q[i] <= '0;
			end
		end else if (accept && (dec.kind == KIND_PAL) && dec.is_write) begin
			pal_q[dec.pal_idx] <= write_data[PAL_DW-1:0];
		end
	end

	// s1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// s1 payload, loaded with the ram access
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_is_write_s1 <= dec.is_write;
			s1_target_s1   <= dec.target;
			s1_eaddr_s1    <= dec.eaddr;
			s1_kind_s1     <= dec.kind;
			s1_edata_s1    <= ext_data;
			s1_evalid_s1   <= ext_valid;
			s1_pal_s1      <= pal_q[dec.pal_idx];
		end
	end

	// read data select and open-bus update
	always_comb begin
		rdata_c  = latch_q;
		latch_we = 1'b0;
		ewrite_c = 1'b0;
		case (s1_kind_s1)
			KIND_WRAM: begin
				rdata_c  = wram_rdata;
				latch_we = !s1_is_write_s1;
			end
			KIND_NT: begin
				rdata_c  = nt_rdata;
				latch_we = !s1_is_write_s1;
			end
			KIND_PAL: begin
				rdata_c = {{(8-PAL_DW){1'b0}}, s1_pal_s1};
			end
			KIND_EXT: begin
				ewrite_c = s1_is_write_s1;
				if (s1_evalid_s1) begin
					rdata_c  = s1_edata_s1;
					latch_we = !s1_is_write_s1;
				end
			end
			KIND_NONE: begin
				rdata_c = latch_q;
			end
			default: begin
				rdata_c = latch_q;
			end
		endcase
		if (s1_is_write_s1) begin
			rdata_c = '0;
		end
	end

	// open-bus latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
		end else if (s1_adv && latch_we) begin
			latch_q <= rdata_c;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data_q   <= rdata_c;
			target_q      <= s1_target_s1;
			ext_address_q <= s1_eaddr_s1;
			ext_write_q   <= ewrite_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign target      = target_q;
	assign ext_address = ext_address_q;
	assign ext_write   = ext_write_q;

	// no access is taken while the rams are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !in_ready)
		else $error("access accepted during ram clear");

	// a stalled s1 item is never dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !out_ready |=> s1_valid_q)
		else $error("s1 item lost under stall");

	// writes forwarded only to external targets
	a_ewrite_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ext_write_q |-> (target_q != TGT_CPU_RAM)
			&& (target_q != TGT_NAMETABLE) && (target_q != TGT_PALETTE)
			&& (target_q != TGT_UNMAPPED) && (read_data_q == 8'd0))
		else $error("external write on internal target");

	// palette reads carry six bits only
	a_pal_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (target_q == TGT_PALETTE) |-> (read_data_q[7:6] == 2'b00))
		else $error("palette read wider than six bits");

	// the latch moves only when a result is produced
	a_latch_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(latch_q))
		else $error("open-bus latch changed without a transfer");

endmodule
